// ----- sv/dkss_pkg.sv -----
// ----------------------------------------------------------------------------
// dkss_pkg
// Shared types and constants for the decimal key shard selector.
// ----------------------------------------------------------------------------
package dkss_pkg;

    localparam int ENTRY_COUNT = 16;
    localparam int MATCH_BITS  = 16;
    localparam int REG_COUNT   = 8;
    localparam int REG_IDX_W   = 3;
    localparam int IDX_W       = 4;
    localparam int KEY_W       = 64;
    localparam int KEY_LOW_W   = 16;
    localparam int CH_W        = 8;

    typedef enum logic [1:0] {
        STATUS_MATCH    = 2'd0,
        STATUS_NO_DIGIT = 2'd1,
        STATUS_NO_MATCH = 2'd2
    } status_t;

    typedef logic [REG_COUNT-1:0][63:0] entry_regs_t;

    // entry i: value i, mask 0x0f
    localparam entry_regs_t ENTRY_RESET = {
        64'h000F_000F_000F_000E,
        64'h000F_000D_000F_000C,
        64'h000F_000B_000F_000A,
        64'h000F_0009_000F_0008,
        64'h000F_0007_000F_0006,
        64'h000F_0005_000F_0004,
        64'h000F_0003_000F_0002,
        64'h000F_0001_000F_0000
    };

    typedef struct packed {
        logic                 has_digit;
        logic [KEY_LOW_W-1:0] key_low;
    } key_info_t;

endpackage

// ----- sv/dkss_parse.sv -----
// ----------------------------------------------------------------------------
// dkss_parse
// Byte-wise decimal parser with saturating 64-bit accumulator.
// ----------------------------------------------------------------------------
module dkss_parse (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     accept,
    input  logic [dkss_pkg::CH_W-1:0] ch,
    input  logic                     last,
    output dkss_pkg::key_info_t      info
);

    typedef enum logic [2:0] {
        PH_SEEK = 3'b001,
        PH_RUN  = 3'b010,
        PH_DONE = 3'b100
    } phase_t;

    phase_t                       phase_reg, phase_next;
    logic [dkss_pkg::KEY_W-1:0]   acc_reg, acc_next;
    logic                         ovf_reg, ovf_next;

    phase_t                       phase_after;
    logic [dkss_pkg::KEY_W-1:0]   acc_after;
    logic                         ovf_after;
    logic                         is_digit;
    logic                         feed;
    logic [dkss_pkg::KEY_W+3:0]   prod;

    assign is_digit = (ch >= 8'h30) && (ch <= 8'h39);

    // acc * 10 + digit, four guard bits catch the carry out
    assign prod = ({4'b0, acc_reg} << 3) + ({4'b0, acc_reg} << 1)
                + {{(dkss_pkg::KEY_W){1'b0}}, ch[3:0]};

    always_comb
    begin
        phase_after = phase_reg;
        feed        = 1'b0;
        unique case (phase_reg)
            PH_SEEK:
            begin
                if (is_digit)
                begin
                    phase_after = PH_RUN;
                    feed        = 1'b1;
                end
            end
            PH_RUN:
            begin
                if (is_digit)
                    feed = 1'b1;
                else
                    phase_after = PH_DONE;
            end
            PH_DONE: phase_after = PH_DONE;
            default: phase_after = PH_DONE;
        endcase
    end

    always_comb
    begin
        acc_after = acc_reg;
        ovf_after = ovf_reg;
        if (feed)
        begin
            if (ovf_reg || (|prod[dkss_pkg::KEY_W+3:dkss_pkg::KEY_W]))
            begin
                acc_after = '1;
                ovf_after = 1'b1;
            end
            else
                acc_after = prod[dkss_pkg::KEY_W-1:0];
        end
    end

    always_comb
    begin
        phase_next = phase_reg;
        acc_next   = acc_reg;
        ovf_next   = ovf_reg;
        if (accept)
        begin
            if (last)
            begin
                phase_next = PH_SEEK;
                acc_next   = '0;
                ovf_next   = 1'b0;
            end
            else
            begin
                phase_next = phase_after;
                acc_next   = acc_after;
                ovf_next   = ovf_after;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_SEEK;
            acc_reg   <= '0;
            ovf_reg   <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            acc_reg   <= acc_next;
            ovf_reg   <= ovf_next;
        end
    end

    assign info.has_digit = (phase_after != PH_SEEK);
    assign info.key_low   = acc_after[dkss_pkg::KEY_LOW_W-1:0];

    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        accept && last |=> phase_reg == PH_SEEK && acc_reg == '0 && !ovf_reg)
        else $error("parser not cleared after last byte");

    a_saturated: assert property (@(posedge clk) disable iff (!rst_n)
        ovf_reg |-> acc_reg == {dkss_pkg::KEY_W{1'b1}})
        else $error("overflowed key not saturated");

endmodule

// ----- sv/dkss_match.sv -----
// ----------------------------------------------------------------------------
// dkss_match
// Parallel masked compare of the key against all entries, first hit wins.
// ----------------------------------------------------------------------------
module dkss_match (
    input  logic [dkss_pkg::KEY_LOW_W-1:0] key_low,
    input  dkss_pkg::entry_regs_t          entries,
    output logic                           hit,
    output logic [dkss_pkg::IDX_W-1:0]     index
);

    localparam logic [15:0] SEL = 16'((32'h1 << dkss_pkg::MATCH_BITS) - 1);

    logic [15:0] val [dkss_pkg::ENTRY_COUNT];
    logic [15:0] msk [dkss_pkg::ENTRY_COUNT];

    for (genvar g = 0; g < dkss_pkg::ENTRY_COUNT; g++)
    begin : g_entry
        assign val[g] = entries[g >> 1][(g & 1) * 32 +: 16] & SEL;
        assign msk[g] = entries[g >> 1][(g & 1) * 32 + 16 +: 16] & SEL;
    end

    always_comb
    begin
        hit   = 1'b0;
        index = '0;
        for (int i = dkss_pkg::ENTRY_COUNT - 1; i >= 0; i--)
        begin
            if ((key_low & msk[i]) == val[i])
            begin
                hit   = 1'b1;
                index = dkss_pkg::IDX_W'(i);
            end
        end
    end

endmodule

// ----- sv/decimal_key_shard_selector.sv -----
// ----------------------------------------------------------------------------
// decimal_key_shard_selector
// Parses a decimal key from a byte stream and selects the first table entry
// whose masked key bits match.
// ----------------------------------------------------------------------------
// Throughput: one byte per cycle unless a stalled result drops s_tready;
//   the shift-add parser folds in each accepted byte. The accepted tlast
//   byte loads the snapshot register, then the compare loads the output register.
// Reset: parser returns to seeking, pipeline empties, table regs take the
//   default entries (entry i = value i, mask 0x0f).
// ----------------------------------------------------------------------------
module decimal_key_shard_selector (
    input  logic                              clk,
    input  logic                              rst_n,
    // configuration
    input  logic                              cfg_we,
    input  logic [dkss_pkg::REG_IDX_W-1:0]    cfg_index,
    input  logic [63:0]                       cfg_data,
    // input stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [7:0]                        s_tdata,   // [7:0] ch
    input  logic                              s_tlast,
    // result stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [23:0]                       m_tdata    // [1:0] status, [5:2] entry_index,
                                                         // [21:6] key_low, [23:22] zero
);

    dkss_pkg::entry_regs_t                cfg_reg;
    dkss_pkg::key_info_t                  info;
    dkss_pkg::key_info_t                  snap_reg;
    logic                                 snap_valid_reg;
    logic                                 out_valid_reg;
    dkss_pkg::status_t                    status_reg;
    logic [dkss_pkg::IDX_W-1:0]           index_reg;
    logic [dkss_pkg::KEY_LOW_W-1:0]       key_low_reg;
    logic                                 accept;
    logic                                 out_adv;
    logic                                 snap_adv;
    logic                                 hit;
    logic [dkss_pkg::IDX_W-1:0]           hit_index;

    assign out_adv  = !out_valid_reg || m_tready;
    assign snap_adv = !snap_valid_reg || out_adv;
    assign s_tready = snap_adv;
    assign accept   = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= dkss_pkg::ENTRY_RESET;
        else if (cfg_we)
            cfg_reg[cfg_index] <= cfg_data;
    end

    dkss_parse u_parse (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .ch     (s_tdata),
        .last   (s_tlast),
        .info   (info)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            snap_valid_reg <= 1'b0;
        else if (snap_adv)
            snap_valid_reg <= accept && s_tlast;
    end

    always_ff @(posedge clk)
    begin
        if (accept && s_tlast)
            snap_reg <= info;
    end

    dkss_match u_match (
        .key_low (snap_reg.key_low),
        .entries (cfg_reg),
        .hit     (hit),
        .index   (hit_index)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_adv)
            out_valid_reg <= snap_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (out_adv && snap_valid_reg)
        begin
            if (!snap_reg.has_digit)
            begin
                status_reg  <= dkss_pkg::STATUS_NO_DIGIT;
                index_reg   <= '0;
                key_low_reg <= '0;
            end
            else
            begin
                status_reg  <= hit ? dkss_pkg::STATUS_MATCH : dkss_pkg::STATUS_NO_MATCH;
                index_reg   <= hit ? hit_index : '0;
                key_low_reg <= snap_reg.key_low;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, key_low_reg, index_reg, status_reg};

    a_no_digit_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && status_reg == dkss_pkg::STATUS_NO_DIGIT
            |-> key_low_reg == '0 && index_reg == '0)
        else $error("no-digit result carries non-zero fields");

    a_no_match_index: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && status_reg == dkss_pkg::STATUS_NO_MATCH |-> index_reg == '0)
        else $error("no-match result carries an index");

    a_snap_held: assert property (@(posedge clk) disable iff (!rst_n)
        snap_valid_reg && !out_adv |=> snap_valid_reg && $stable(snap_reg))
        else $error("snapshot lost while output stalled");

endmodule
